### rtl/core/pgw_pkg.sv
// Shared types, codes and saturation helpers of the particle gravity-well update block.
package pgw_pkg;

    // Width of the signed force accumulators and saturation workspace.
    localparam int ACC_W = 48;

    localparam logic signed [ACC_W-1:0] S32_MAX_W = 48'sd2147483647;
    localparam logic signed [ACC_W-1:0] S32_MIN_W = -48'sd2147483648;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BOUND_RANGE   = 2'd0;
    localparam logic [1:0] CFG_SPEED_FLOOR   = 2'd1;
    localparam logic [1:0] CFG_SPEED_CEILING = 2'd2;
    localparam logic [1:0] CFG_ACTIVE_WELLS  = 2'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE, S_W_CHECK, S_W_DIFF, S_W_SQ, S_W_ACC, S_SQRT_GO, S_D_FIX,
        S_Q_GO, S_Q_FIX, S_PULL_GO, S_PULL_FIX, S_UNIT_GO, S_C_MUL, S_C_ADD,
        S_BOUNCE, S_V_SQ, S_V_ACC, S_SPD_GO, S_SPD_FIX, S_SCL_MUL, S_SCL_GO,
        S_SCL_FIX, S_INT_VM, S_INT_VA, S_INT_PM, S_INT_PA, S_FIN, S_WAIT
    } t_state;

    // Operation of the shared divide / square-root unit.
    typedef enum logic {
        DS_DIV,
        DS_SQRT
    } t_ds_op;

    typedef struct packed {
        logic   start;
        t_ds_op op;
    } t_ds_ctl;

    // One entry of the well table.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] size;
    } t_well;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX_W) begin
            r = 32'sh7FFFFFFF;
        end else if (v < S32_MIN_W) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Magnitude of a signed 32-bit value; the most negative value gives 2^31.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    // Apply a sign to an unsigned magnitude and saturate to 32 bits.
    function automatic logic signed [31:0] sat_sign(input logic neg, input logic [63:0] m);
        logic signed [31:0] r;
        if (neg) begin
            r = (m > 64'd2147483648) ? 32'sh80000000 : (~m[31:0] + 32'd1);
        end else begin
            r = (m > 64'd2147483647) ? 32'sh7FFFFFFF : m[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/pgw_if.sv
// Handshake interfaces for the update, result and configuration channels.
interface pgw_upd_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [3:0]         well_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] well_strength;
    logic [15:0]        time_step;

    modport source (
        output valid, req_type, well_index, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, well_strength, time_step,
        input  ready
    );
    modport sink (
        input  valid, req_type, well_index, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, well_strength, time_step,
        output ready
    );
endinterface

interface pgw_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic signed [31:0] new_vx;
    logic signed [31:0] new_vy;
    logic signed [31:0] new_vz;

    modport source (
        output valid, new_x, new_y, new_z, new_vx, new_vy, new_vz,
        input  ready
    );
    modport sink (
        input  valid, new_x, new_y, new_z, new_vx, new_vy, new_vz,
        output ready
    );
endinterface

interface pgw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/particle_gravity_well_update_top.sv
// Particle gravity-well update: sequencer, datapath and configuration registers.
// A load beat gives no result.
// An update's result goes to the output register once the sequencer has run every active
// well, and the speed rescale when it is needed; the next beat is taken after that. Each divide
// holds the shared unit for 64 iterations, and each square root holds it as well.
// Synchronous active-low reset restores the register defaults; well table is unset.
module particle_gravity_well_update_top #(
    parameter int WELLS_MAX = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pgw_upd_if.sink     i_upd,
    pgw_res_if.source   o_res,
    pgw_cfg_if.sink     i_cfg
);
    import pgw_pkg::*;

    localparam int AW          = (WELLS_MAX > 1) ? $clog2(WELLS_MAX) : 1;
    localparam int CW          = $clog2(WELLS_MAX + 1);
    localparam int DF_RAW      = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int DIST_FLOOR  = (DF_RAW > 0) ? DF_RAW : 1;
    localparam logic [63:0] Q_CAP = (64'd1 << (63 - FRAC_BITS)) - 64'd1;

    // Configuration registers.
    logic [30:0] r_bound;
    logic [30:0] r_floor;
    logic [30:0] r_ceil;
    logic [4:0]  r_active;

    // Sequencer.
    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic [1:0]  r_k;

    // Particle and per-well working registers.
    logic signed [31:0]      r_p   [3];
    logic signed [31:0]      r_v   [3];
    logic signed [31:0]      r_a   [3];
    logic signed [31:0]      r_dv  [3];
    logic signed [ACC_W-1:0] r_acc [3];
    logic [15:0]             r_dt;
    logic [CW-1:0]           r_wcnt;
    logic [CW-1:0]           r_n;
    logic [63:0]             r_d2;
    logic [31:0]             r_d;
    logic [63:0]             r_q;
    logic [30:0]             r_pull;
    logic [31:0]             r_s;
    logic [30:0]             r_target;
    logic [63:0]             r_prod;

    // Output register.
    logic                    r_ovalid;
    logic signed [31:0]      r_op [3];
    logic signed [31:0]      r_ov [3];

    // Shared unit and multiplier connections.
    t_ds_ctl     ds_ctl;
    logic [63:0] ds_num;
    logic [31:0] ds_den;
    logic        ds_done;
    logic [63:0] ds_res;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // Well table connections.
    logic        well_we;
    t_well       well_wdata;
    t_well       well_rd;

    logic        upd_acc;
    logic        spd_low;
    logic        spd_high;
    logic        spd_scale;

    assign upd_acc = i_upd.valid && i_upd.ready;
    assign mul_p   = 64'(mul_a) * 64'(mul_b);

    assign spd_low   = (ds_res[31:0] < {1'b0, r_floor});
    assign spd_high  = (ds_res[31:0] > {1'b0, r_ceil});
    assign spd_scale = (ds_res[31:0] != 32'd0) && (spd_low || spd_high);

    // Load beats go straight into the table.
    assign well_we         = upd_acc && !i_upd.req_type && (32'(i_upd.well_index) < WELLS_MAX);
    assign well_wdata.x    = i_upd.pos_x;
    assign well_wdata.y    = i_upd.pos_y;
    assign well_wdata.z    = i_upd.pos_z;
    assign well_wdata.size = i_upd.well_strength;

    pgw_wells #(
        .WELLS_MAX (WELLS_MAX),
        .AW        (AW)
    ) u_wells (
        .i_clk   (i_clk),
        .i_we    (well_we),
        .i_waddr (AW'(i_upd.well_index)),
        .i_wdata (well_wdata),
        .i_raddr (r_wcnt[AW-1:0]),
        .o_rdata (well_rd)
    );

    pgw_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ds_ctl),
        .i_num   (ds_num),
        .i_den   (ds_den),
        .o_done  (ds_done),
        .o_res   (ds_res)
    );

    // Configuration writes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound  <= 31'd655360;
            r_floor  <= 31'd65536;
            r_ceil   <= 31'd327680;
            r_active <= 5'd0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BOUND_RANGE:   r_bound  <= i_cfg.data[30:0];
                CFG_SPEED_FLOOR:   r_floor  <= i_cfg.data[30:0];
                CFG_SPEED_CEILING: r_ceil   <= i_cfg.data[30:0];
                CFG_ACTIVE_WELLS:  r_active <= i_cfg.data[4:0];
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // Next state, shared unit requests and multiplier operands.
    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        ds_ctl.start = 1'b0;
        ds_ctl.op    = DS_DIV;
        ds_num       = '0;
        ds_den       = r_d;
        mul_a        = '0;
        mul_b        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (upd_acc && i_upd.req_type) n_state = S_W_CHECK;
            end
            S_W_CHECK: n_state = (r_wcnt == r_n) ? S_BOUNCE : S_W_DIFF;
            S_W_DIFF:  n_state = S_W_SQ;
            S_W_SQ: begin
                mul_a   = mag32(r_dv[r_k]);
                mul_b   = mag32(r_dv[r_k]);
                n_state = S_W_ACC;
            end
            S_W_ACC: n_state = (r_k == 2'd2) ? S_SQRT_GO : S_W_SQ;
            S_SQRT_GO: begin
                ds_ctl.start = 1'b1;
                ds_ctl.op    = DS_SQRT;
                ds_num       = r_d2;
                n_ret        = S_D_FIX;
                n_state      = S_WAIT;
            end
            S_D_FIX: n_state = S_Q_GO;
            S_Q_GO: begin
                ds_ctl.start = 1'b1;
                ds_num       = 64'({mag32(well_rd.size), 1'b0}) << FRAC_BITS;
                n_ret        = S_Q_FIX;
                n_state      = S_WAIT;
            end
            S_Q_FIX: n_state = S_PULL_GO;
            S_PULL_GO: begin
                ds_ctl.start = 1'b1;
                ds_num       = r_q << FRAC_BITS;
                n_ret        = S_PULL_FIX;
                n_state      = S_WAIT;
            end
            S_PULL_FIX: n_state = S_UNIT_GO;
            S_UNIT_GO: begin
                ds_ctl.start = 1'b1;
                ds_num       = 64'(mag32(r_dv[r_k])) << FRAC_BITS;
                n_ret        = S_C_MUL;
                n_state      = S_WAIT;
            end
            S_C_MUL: begin
                mul_a   = {1'b0, r_pull};
                mul_b   = ds_res[31:0];
                n_state = S_C_ADD;
            end
            S_C_ADD:  n_state = (r_k == 2'd2) ? S_W_CHECK : S_UNIT_GO;
            S_BOUNCE: n_state = S_V_SQ;
            S_V_SQ: begin
                mul_a   = mag32(r_v[r_k]);
                mul_b   = mag32(r_v[r_k]);
                n_state = S_V_ACC;
            end
            S_V_ACC: n_state = (r_k == 2'd2) ? S_SPD_GO : S_V_SQ;
            S_SPD_GO: begin
                ds_ctl.start = 1'b1;
                ds_ctl.op    = DS_SQRT;
                ds_num       = r_d2;
                n_ret        = S_SPD_FIX;
                n_state      = S_WAIT;
            end
            S_SPD_FIX: n_state = spd_scale ? S_SCL_MUL : S_INT_VM;
            S_SCL_MUL: begin
                mul_a   = mag32(r_v[r_k]);
                mul_b   = {1'b0, r_target};
                n_state = S_SCL_GO;
            end
            S_SCL_GO: begin
                ds_ctl.start = 1'b1;
                ds_num       = r_prod;
                ds_den       = r_s;
                n_ret        = S_SCL_FIX;
                n_state      = S_WAIT;
            end
            S_SCL_FIX: n_state = (r_k == 2'd2) ? S_INT_VM : S_SCL_MUL;
            S_INT_VM: begin
                mul_a   = mag32(r_a[r_k]);
                mul_b   = 32'(r_dt);
                n_state = S_INT_VA;
            end
            S_INT_VA: n_state = S_INT_PM;
            S_INT_PM: begin
                mul_a   = mag32(r_v[r_k]);
                mul_b   = 32'(r_dt);
                n_state = S_INT_PA;
            end
            S_INT_PA: n_state = (r_k == 2'd2) ? S_FIN : S_INT_VM;
            S_FIN: begin
                if (!r_ovalid || o_res.ready) n_state = S_IDLE;
            end
            S_WAIT: begin
                if (ds_done) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_upd.ready = (r_state == S_IDLE);

    // Axis counter: wraps after the third axis so every loop starts at x.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 2'd0;
        end else begin
            case (r_state)
                S_W_DIFF, S_PULL_FIX, S_BOUNCE, S_SPD_FIX: r_k <= 2'd0;
                S_W_ACC, S_C_ADD, S_V_ACC, S_SCL_FIX, S_INT_PA: begin
                    r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        logic signed [ACC_W-1:0] c;
        logic signed [ACC_W-1:0] t;
        c = ACC_W'(r_prod >> FRAC_BITS);
        t = ACC_W'(r_prod >> 16);
        case (r_state)
            S_IDLE: begin
                if (upd_acc && i_upd.req_type) begin
                    r_p[0] <= i_upd.pos_x;
                    r_p[1] <= i_upd.pos_y;
                    r_p[2] <= i_upd.pos_z;
                    r_v[0] <= i_upd.vel_x;
                    r_v[1] <= i_upd.vel_y;
                    r_v[2] <= i_upd.vel_z;
                    r_dt   <= i_upd.time_step;
                    for (int k = 0; k < 3; k++) r_acc[k] <= '0;
                    r_wcnt <= '0;
                    r_n    <= (32'(r_active) < WELLS_MAX) ? CW'(r_active) : CW'(WELLS_MAX);
                end
            end
            S_W_DIFF: begin
                r_dv[0] <= sat48(ACC_W'(well_rd.x) - ACC_W'(r_p[0]));
                r_dv[1] <= sat48(ACC_W'(well_rd.y) - ACC_W'(r_p[1]));
                r_dv[2] <= sat48(ACC_W'(well_rd.z) - ACC_W'(r_p[2]));
                r_d2    <= '0;
            end
            S_W_SQ, S_V_SQ, S_C_MUL, S_SCL_MUL, S_INT_VM, S_INT_PM: r_prod <= mul_p;
            S_W_ACC, S_V_ACC: r_d2 <= r_d2 + r_prod;
            S_D_FIX: begin
                r_d <= (ds_res <= 64'(DIST_FLOOR)) ? 32'(DIST_FLOOR) : ds_res[31:0];
            end
            S_Q_FIX: r_q <= (ds_res > Q_CAP) ? Q_CAP : ds_res;
            S_PULL_FIX: r_pull <= (ds_res > 64'h7FFFFFFF) ? 31'h7FFFFFFF : ds_res[30:0];
            S_C_ADD: begin
                if (r_dv[r_k][31] ^ well_rd.size[31]) begin
                    r_acc[r_k] <= r_acc[r_k] - c;
                end else begin
                    r_acc[r_k] <= r_acc[r_k] + c;
                end
                if (r_k == 2'd2) r_wcnt <= r_wcnt + CW'(1);
            end
            S_BOUNCE: begin
                // Saturate the pull sums and reflect axes outside the box.
                for (int k = 0; k < 3; k++) begin
                    r_a[k] <= sat48(r_acc[k]);
                    if ($signed({r_p[k][31], r_p[k]}) > $signed({2'b00, r_bound}) ||
                        $signed({r_p[k][31], r_p[k]}) < -$signed({2'b00, r_bound})) begin
                        r_v[k] <= sat48(-ACC_W'(r_v[k]));
                    end
                end
                r_d2 <= '0;
            end
            S_SPD_FIX: begin
                r_s      <= ds_res[31:0];
                r_target <= spd_low ? r_floor : r_ceil;
            end
            S_SCL_FIX: r_v[r_k] <= sat_sign(r_v[r_k][31], ds_res);
            S_INT_VA: begin
                if (r_a[r_k][31]) begin
                    r_v[r_k] <= sat48(ACC_W'(r_v[r_k]) - t);
                end else begin
                    r_v[r_k] <= sat48(ACC_W'(r_v[r_k]) + t);
                end
            end
            S_INT_PA: begin
                if (r_v[r_k][31]) begin
                    r_p[r_k] <= sat48(ACC_W'(r_p[r_k]) - t);
                end else begin
                    r_p[r_k] <= sat48(ACC_W'(r_p[r_k]) + t);
                end
            end
            default: ;
        endcase
    end

    // Output register: loaded when the result is done and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_FIN && (!r_ovalid || o_res.ready)) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_ovalid || o_res.ready)) begin
            for (int k = 0; k < 3; k++) begin
                r_op[k] <= r_p[k];
                r_ov[k] <= r_v[k];
            end
        end
    end

    assign o_res.valid  = r_ovalid;
    assign o_res.new_x  = r_op[0];
    assign o_res.new_y  = r_op[1];
    assign o_res.new_z  = r_op[2];
    assign o_res.new_vx = r_ov[0];
    assign o_res.new_vy = r_ov[1];
    assign o_res.new_vz = r_ov[2];

endmodule

### rtl/core/pgw_divsqrt.sv
// Shared iterative unit: restoring 64/32 division or 64-bit integer square root.
module pgw_divsqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pgw_pkg::t_ds_ctl i_ctl,
    input  logic [63:0]      i_num,
    input  logic [31:0]      i_den,
    output logic             o_done,
    output logic [63:0]      o_res
);
    import pgw_pkg::*;

    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    t_ds_op      r_op;
    logic [31:0] r_den;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_x;
    logic [63:0] r_root;
    logic [63:0] r_bit;

    logic [32:0] div_trial;
    logic        div_fit;
    logic [63:0] sq_trial;
    logic        sq_fit;

    // One quotient bit or one root bit per cycle.
    always_comb begin
        div_trial = {r_rem, r_quo[63]};
        div_fit   = (div_trial >= {1'b0, r_den});
        sq_trial  = r_root + r_bit;
        sq_fit    = (r_x >= sq_trial);
    end

    // Sequencing of the iterations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctl.op == DS_SQRT) ? SQRT_LAST : DIV_LAST;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath of the shared unit.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op   <= i_ctl.op;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= i_num;
            r_x    <= i_num;
            r_root <= '0;
            r_bit  <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_op == DS_DIV) begin
                r_rem <= div_fit ? 32'(div_trial - {1'b0, r_den}) : div_trial[31:0];
                r_quo <= {r_quo[62:0], div_fit};
            end else begin
                if (sq_fit) begin
                    r_x    <= r_x - sq_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == DS_SQRT) ? r_root : r_quo;

endmodule

### rtl/core/pgw_wells.sv
// Well table memory with one write port and one registered read port.
module pgw_wells #(
    parameter int WELLS_MAX = 16,
    parameter int AW        = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pgw_pkg::t_well  i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output pgw_pkg::t_well  o_rdata
);
    import pgw_pkg::*;

    t_well r_mem [WELLS_MAX];
    t_well r_rdata;

    // Write on load beats, read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
